[hw/rtl/mpq_pkg.sv]
// Shared types and constants for the min priority queue unit.
package mpq_pkg;

   localparam int KEY_WIDTH    = 32;
   localparam int OP_WIDTH     = 2;
   localparam int OCC_WIDTH    = 7;
   localparam int DEF_CAPACITY = 64;

   localparam logic [OP_WIDTH-1:0] OP_INSERT  = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_FIND    = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_EXTRACT = 2'd2;

   // Command broadcast to every cell of the sorted row.
   typedef struct packed {
      logic                        insert;
      logic                        extract;
      logic signed [KEY_WIDTH-1:0] key;
   } cell_cmd_type;

endpackage

[hw/rtl/mpq_cell.sv]
// One slot of the sorted key row: keeps, takes the new key, or shifts.
module mpq_cell
   import mpq_pkg::*;
(
   input  logic                        clock,
   input  cell_cmd_type                cmd,
   input  logic                        occupied,
   input  logic                        left_le,
   input  logic signed [KEY_WIDTH-1:0] left_key,
   input  logic signed [KEY_WIDTH-1:0] right_key,
   output logic signed [KEY_WIDTH-1:0] key_ff,
   output logic                        own_le
);

   logic signed [KEY_WIDTH-1:0] key_in;

   // slot holds a key not above the incoming one: it stays put
   assign own_le = occupied && (key_ff <= cmd.key);

   always_comb begin
      key_in = key_ff;
      if (cmd.insert) begin
         if (!own_le) begin
            key_in = left_le ? cmd.key : left_key;
         end
      end else if (cmd.extract) begin
         key_in = right_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

[hw/rtl/min_priority_queue_unit.sv]
// Top level: min priority queue built as a sorted row of key cells.
// The response register is loaded in the cycle its request beat is accepted.
// Throughput: one operation per cycle while no response beat is held;
//   every op is a single update of the cell row, key broadcast to all cells.
// Reset: clears the key count and the response valid; cell keys are not
//   cleared and no clearing pass runs, so requests are taken right away.
module min_priority_queue_unit
   import mpq_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [OP_WIDTH-1:0]         req_operation,
   input  logic signed [KEY_WIDTH-1:0] req_key_in,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [KEY_WIDTH-1:0] rsp_min_key,
   output logic                        rsp_found,
   output logic                        rsp_full_error,
   output logic [OCC_WIDTH-1:0]        rsp_occupancy
);

   localparam int CNT_WIDTH = $clog2(CAPACITY + 1);

   // Cell i holds the (i+1)-th smallest key; cell 0 is always the minimum.
   // Cells at index count and above hold stale data and are never reported.
   logic [CNT_WIDTH-1:0]        count_ff, count_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [KEY_WIDTH-1:0] rsp_min_key_ff, rsp_min_key_in;
   logic                        rsp_found_ff, rsp_found_in;
   logic                        rsp_full_error_ff, rsp_full_error_in;

   logic                        accept;
   logic                        is_full;
   logic                        is_empty;
   logic                        do_insert;
   logic                        do_extract;
   cell_cmd_type                cmd;

   logic signed [KEY_WIDTH-1:0] cell_key [CAPACITY];
   logic                        cell_le  [CAPACITY];

   // Output register frees the input side unless a response beat is held.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign is_full    = (count_ff == CNT_WIDTH'(CAPACITY));
   assign is_empty   = (count_ff == '0);
   assign do_insert  = accept && (req_operation == OP_INSERT) && !is_full;
   assign do_extract = accept && (req_operation == OP_EXTRACT) && !is_empty;

   assign cmd.insert  = do_insert;
   assign cmd.extract = do_extract;
   assign cmd.key     = req_key_in;

   // Sorted row: insert opens a gap at the first larger key, extract
   // shifts every cell one place toward the head.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                        left_le;
      logic signed [KEY_WIDTH-1:0] left_key;
      logic signed [KEY_WIDTH-1:0] right_key;

      if (i == 0) begin : g_head
         assign left_le  = 1'b1;
         assign left_key = req_key_in;
      end else begin : g_body
         assign left_le  = cell_le[i-1];
         assign left_key = cell_key[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_key = cell_key[i];
      end else begin : g_mid
         assign right_key = cell_key[i+1];
      end

      mpq_cell u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .occupied  (count_ff > CNT_WIDTH'(i)),
         .left_le   (left_le),
         .left_key  (left_key),
         .right_key (right_key),
         .key_ff    (cell_key[i]),
         .own_le    (cell_le[i])
      );
   end

   // Response is formed from the row before this beat's update.
   always_comb begin
      count_in          = count_ff;
      rsp_valid_in      = rsp_valid_ff & rsp_stall;
      rsp_min_key_in    = rsp_min_key_ff;
      rsp_found_in      = rsp_found_ff;
      rsp_full_error_in = rsp_full_error_ff;
      if (accept) begin
         rsp_valid_in      = 1'b1;
         rsp_min_key_in    = '0;
         rsp_found_in      = 1'b0;
         rsp_full_error_in = 1'b0;
         case (req_operation)
            OP_INSERT: begin
               if (is_full) begin
                  rsp_full_error_in = 1'b1;
               end else begin
                  count_in = count_ff + CNT_WIDTH'(1);
               end
            end
            OP_FIND, OP_EXTRACT: begin
               if (!is_empty) begin
                  rsp_min_key_in = cell_key[0];
                  rsp_found_in   = 1'b1;
                  if (req_operation == OP_EXTRACT) begin
                     count_in = count_ff - CNT_WIDTH'(1);
                  end
               end
            end
            default: begin
               // unused code: no-op, reports current occupancy
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_min_key_ff    <= rsp_min_key_in;
      rsp_found_ff      <= rsp_found_in;
      rsp_full_error_ff <= rsp_full_error_in;
   end

   // Occupancy tracks the count live; it only changes on an accepted beat,
   // which requires the previous response to have been taken.
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_min_key    = rsp_min_key_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_full_error = rsp_full_error_ff;
   assign rsp_occupancy  = OCC_WIDTH'(count_ff);

   // Count never runs past the row length.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_WIDTH'(CAPACITY))
      else $error("key count above capacity");

   // Head two cells stay ordered whenever both hold keys.
   a_head_sorted : assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CNT_WIDTH'(2)) |-> (cell_key[0] <= cell_key[1]))
      else $error("cell row out of order at head");

   // A refused insert leaves the row count unchanged.
   a_full_hold : assert property (@(posedge clock) disable iff (reset)
      (accept && req_operation == OP_INSERT && is_full) |=> $stable(count_ff))
      else $error("count moved on refused insert");

   // A response never reports a key and a refused insert together.
   a_flags_excl : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_found_ff && rsp_full_error_ff))
      else $error("found and full_error both set");

endmodule

[test/tb_top.sv]
// Self-checking testbench for the min priority queue unit.
`timescale 1ns / 1ps

module tb_top;
   import mpq_pkg::*;

   // --------------------------------------------------------------------
   // Run constants
   // --------------------------------------------------------------------
   localparam int CAPACITY    = DEF_CAPACITY;
   localparam int IDLE_LIMIT  = 3000;   // cycles with no beat on either side
   localparam int HOLD_CYCLES = 300;    // long receiver hold-off
   localparam int NUM_PHASES  = 8;
   localparam int PHASE_ITEMS = 150;    // 8 x 150 random beats

   // Code three has no package name; the block treats it as a no-op.
   localparam logic [OP_WIDTH-1:0] OP_NOP = 2'd3;

   localparam logic signed [KEY_WIDTH-1:0] KEY_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [KEY_WIDTH-1:0] KEY_MIN = 32'sh8000_0000;

   // Mix of operations per phase: fill, mixed, drain.
   localparam int MIX_FILL  = 0;
   localparam int MIX_MIXED = 1;
   localparam int MIX_DRAIN = 2;

   // Receiver stall patterns.
   localparam int STALL_NONE     = 0;
   localparam int STALL_LIGHT    = 1;
   localparam int STALL_HEAVY    = 2;
   localparam int STALL_PERIODIC = 3;

   typedef struct {
      logic signed [KEY_WIDTH-1:0] min_key;
      logic                        found;
      logic                        full_error;
      logic [OCC_WIDTH-1:0]        occupancy;
   } queue_result_type;

   // --------------------------------------------------------------------
   // Scoreboard: keeps its own multiset of keys, predicts each response
   // at request acceptance and compares responses in order.
   // --------------------------------------------------------------------
   class queue_scoreboard;
      logic signed [KEY_WIDTH-1:0] held_keys[$];
      queue_result_type            pending_results[$];
      int mismatches;
      int checked;
      int n_inserts, n_refused, n_empty, n_hits, n_nops;

      function new();
         mismatches = 0;
         checked    = 0;
         n_inserts  = 0;
         n_refused  = 0;
         n_empty    = 0;
         n_hits     = 0;
         n_nops     = 0;
      endfunction

      function int outstanding();
         return pending_results.size();
      endfunction

      function int held();
         return held_keys.size();
      endfunction

      // Work out the response of one accepted request and update the keys.
      function void note_request(logic [OP_WIDTH-1:0] op,
                                 logic signed [KEY_WIDTH-1:0] key);
         queue_result_type r;
         int best;
         r.min_key    = '0;
         r.found      = 1'b0;
         r.full_error = 1'b0;
         case (op)
            OP_INSERT: begin
               if (held_keys.size() < CAPACITY) begin
                  held_keys = {held_keys, key};
                  n_inserts++;
               end else begin
                  r.full_error = 1'b1;
                  n_refused++;
               end
            end
            OP_FIND, OP_EXTRACT: begin
               if (held_keys.size() == 0) begin
                  n_empty++;
               end else begin
                  // lowest index wins on ties
                  best = 0;
                  for (int i = 1; i < held_keys.size(); i++)
                     if (held_keys[i] < held_keys[best]) best = i;
                  r.min_key = held_keys[best];
                  r.found   = 1'b1;
                  n_hits++;
                  if (op == OP_EXTRACT) begin
                     held_keys[best] = held_keys[held_keys.size() - 1];
                     void'(held_keys.pop_back());
                  end
               end
            end
            default: n_nops++;
         endcase
         r.occupancy = OCC_WIDTH'(held_keys.size());
         pending_results = {pending_results, r};
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         if (mismatches <= 30) $display("MISMATCH at %0t: %s", $time, msg);
      endtask

      // Compare one accepted response beat with the oldest prediction.
      task check_response(logic signed [KEY_WIDTH-1:0] min_key, logic found,
                          logic full_error, logic [OCC_WIDTH-1:0] occupancy);
         queue_result_type want;
         if (pending_results.size() == 0) begin
            report_mismatch("response beat with no request outstanding");
         end else begin
            want = pending_results.pop_front();
            checked++;
            if (min_key !== want.min_key)
               report_mismatch($sformatf("beat %0d min_key %0d, want %0d",
                                         checked, min_key, want.min_key));
            if (found !== want.found)
               report_mismatch($sformatf("beat %0d found %b, want %b",
                                         checked, found, want.found));
            if (full_error !== want.full_error)
               report_mismatch($sformatf("beat %0d full_error %b, want %b",
                                         checked, full_error, want.full_error));
            if (occupancy !== want.occupancy)
               report_mismatch($sformatf("beat %0d occupancy %0d, want %0d",
                                         checked, occupancy, want.occupancy));
         end
      endtask
   endclass

   // --------------------------------------------------------------------
   // Clock, reset and DUT
   // --------------------------------------------------------------------
   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [OP_WIDTH-1:0]         req_operation = OP_NOP;
   logic signed [KEY_WIDTH-1:0] req_key_in = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic signed [KEY_WIDTH-1:0] rsp_min_key;
   logic                        rsp_found;
   logic                        rsp_full_error;
   logic [OCC_WIDTH-1:0]        rsp_occupancy;

   always #5 clock = ~clock;

   min_priority_queue_unit #(.CAPACITY(CAPACITY)) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_key_in    (req_key_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_min_key   (rsp_min_key),
      .rsp_found     (rsp_found),
      .rsp_full_error(rsp_full_error),
      .rsp_occupancy (rsp_occupancy)
   );

   queue_scoreboard sb = new();

   // Sender / receiver pacing state, shared between processes.
   bit bursty       = 1'b0;
   int burst_left   = 0;
   int stall_mode   = STALL_NONE;
   bit hold_request = 1'b0;
   int hold_left    = 0;
   int holds_done   = 0;
   int stall_tick   = 0;
   int items_sent   = 0;
   int idle_cycles  = 0;
   int peak_held    = 0;

   // --------------------------------------------------------------------
   // Receiver: stall pattern driven at the falling edge. A long hold-off
   // is requested by the stimulus and counted down here, so the sender
   // keeps offering beats while the output side is blocked.
   // --------------------------------------------------------------------
   always @(negedge clock) begin
      stall_tick++;
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
         holds_done++;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 7);
            default:     rsp_stall <= ((stall_tick % 7) < 3);
         endcase
      end
   end

   // Response monitor: every accepted beat goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_min_key, rsp_found, rsp_full_error, rsp_occupancy);
   end

   // Watchdog: ends the run if neither channel moves a beat for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no beat for %0d cycles, %0d responses outstanding",
                  idle_cycles, sb.outstanding());
         $display("** min_priority_queue_unit: FAILED **");
         $finish;
      end
   end

   // --------------------------------------------------------------------
   // Sender tasks
   // --------------------------------------------------------------------

   // Offer one request beat and wait for it to be taken.
   task automatic send_beat(input logic [OP_WIDTH-1:0] op,
                            input logic signed [KEY_WIDTH-1:0] key);
      @(negedge clock);
      req_valid     <= 1'b1;
      req_operation <= op;
      req_key_in    <= key;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(op, key);
      items_sent++;
      if (sb.held() > peak_held) peak_held = sb.held();
   endtask

   // Drop valid for a number of cycles.
   task automatic idle_gap(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // One request, with burst / gap pacing when the sender is bursty.
   task automatic issue(input logic [OP_WIDTH-1:0] op,
                        input logic signed [KEY_WIDTH-1:0] key);
      if (bursty && burst_left == 0) begin
         idle_gap($urandom_range(1, 8));
         burst_left = $urandom_range(1, 40);
      end
      send_beat(op, key);
      if (burst_left > 0) burst_left--;
   endtask

   // Hold the sender until every predicted response has arrived.
   task automatic drain_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   // Keys lean on the extremes, -1 and a narrow band to force ties.
   function automatic logic signed [KEY_WIDTH-1:0] pick_key();
      case ($urandom_range(0, 9))
         0:       return KEY_MIN;
         1:       return KEY_MAX;
         2:       return -32'sd1;
         3:       return 32'sd0;
         4, 5:    return $signed(32'($urandom_range(0, 8))) - 32'sd4;
         default: return $signed($urandom());
      endcase
   endfunction

   function automatic logic [OP_WIDTH-1:0] pick_op(input int mix);
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return OP_NOP;
      case (mix)
         MIX_FILL:  return (r < 75) ? OP_INSERT : (r < 85) ? OP_FIND : OP_EXTRACT;
         MIX_DRAIN: return (r < 30) ? OP_INSERT : (r < 45) ? OP_FIND : OP_EXTRACT;
         default:   return (r < 50) ? OP_INSERT : (r < 70) ? OP_FIND : OP_EXTRACT;
      endcase
   endfunction

   // --------------------------------------------------------------------
   // Stimulus
   // --------------------------------------------------------------------
   initial begin
      int mix_plan[NUM_PHASES] = '{MIX_FILL, MIX_MIXED, MIX_DRAIN, MIX_FILL,
                                   MIX_MIXED, MIX_DRAIN, MIX_FILL, MIX_DRAIN};

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Directed: empty queue, no-op, INT_MAX and -1 as real keys, the
      // most negative key, ties on -1, then drain past empty.
      issue(OP_FIND,    '0);
      issue(OP_EXTRACT, '0);
      issue(OP_NOP,     32'sh5A5A_A5A5);
      issue(OP_INSERT,  KEY_MAX);
      issue(OP_FIND,    '0);
      issue(OP_INSERT,  -32'sd1);
      issue(OP_FIND,    '0);
      issue(OP_INSERT,  KEY_MIN);
      issue(OP_INSERT,  32'sd0);
      issue(OP_INSERT,  -32'sd1);
      issue(OP_NOP,     '0);
      issue(OP_EXTRACT, '0);
      issue(OP_EXTRACT, '0);
      issue(OP_EXTRACT, '0);
      issue(OP_EXTRACT, '0);
      issue(OP_EXTRACT, '0);
      issue(OP_EXTRACT, '0);
      issue(OP_FIND,    '0);
      issue(OP_INSERT,  32'sd5);
      issue(OP_EXTRACT, 32'shFFFF_FFFF);

      // Random phases. Phase 0 runs with no idling at all; fill phases
      // push the queue to capacity so refused inserts show up.
      for (int p = 0; p < NUM_PHASES; p++) begin
         bursty     = (p != 0 && p != 5);
         burst_left = 0;
         stall_mode = (p == 0) ? STALL_NONE : (p % 4);
         if (p == 4) drain_responses();
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // long output hold-off while the sender keeps pushing
            if (p == 3 && n == 20) hold_request = 1'b1;
            issue(pick_op(mix_plan[p]), pick_key());
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (5) @(posedge clock);

      $display("run: %0d requests, %0d responses checked, %0d inserts, %0d refused (full)",
               items_sent, sb.checked, sb.n_inserts, sb.n_refused);
      $display("     %0d min hits, %0d empty reads, %0d no-ops, peak %0d keys, %0d hold-offs",
               sb.n_hits, sb.n_empty, sb.n_nops, peak_held, holds_done);
      if (sb.mismatches == 0) begin
         $display("** min_priority_queue_unit: PASSED **");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("** min_priority_queue_unit: FAILED **");
      end
      $finish;
   end

endmodule
